// ===== src/tans_pkg.sv =====
// Shared types and constants for the tANS table build and encode block.
package tans_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_ENCODE = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_BUILD = 2'd1;
   localparam logic [1:0] KIND_FINAL = 2'd2;

   localparam logic [1:0] CSR_TABLE_LOG     = 2'd0;
   localparam logic [1:0] CSR_SPREAD_STEP   = 2'd1;
   localparam logic [1:0] CSR_ALPHABET_SIZE = 2'd2;

   localparam logic [3:0]  TABLE_LOG_RESET     = 4'd12;
   localparam logic [11:0] SPREAD_STEP_RESET   = 12'd2563;
   localparam logic [8:0]  ALPHABET_SIZE_RESET = 9'd256;
   localparam logic [3:0]  MIN_TABLE_LOG       = 4'd5;
   localparam logic [3:0]  BYTE_BITS           = 4'd8;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  symbol;
      logic [12:0] frequency;
   } item_type;

   typedef struct packed {
      logic [3:0]  table_log;
      logic [11:0] spread_step;
      logic [8:0]  alphabet_size;
   } csr_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [3:0]  bits_in_byte;
      logic [11:0] final_state;
      logic        last;
   } rsp_type;

endpackage

// ===== src/tans_front.sv =====
// Front end: takes request words, drops ignored ones, queues the rest.
module tans_front import tans_pkg::*; #(
   parameter int ALPHABET = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [12:0] req_frequency,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       drop;
   logic       push;
   cmd_type    cmd;

   assign cmd       = cmd_type'(req_cmd);
   assign req_ready = (count_ff != 2'd2);
   // drop loads and encodes of symbols outside the alphabet
   assign drop = ((cmd == CMD_LOAD) || (cmd == CMD_ENCODE)) &&
                 (9'(req_symbol) >= 9'(ALPHABET));
   assign push = req_valid && req_ready && !drop;

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{cmd: cmd, symbol: req_symbol, frequency: req_frequency};
      end
   end

endmodule

// ===== src/tans_back.sv =====
// Back end: table build sequencer, symbol encoder and result register.
module tans_back import tans_pkg::*; #(
   parameter int MAX_TABLE_LOG = 12,
   parameter int ALPHABET      = 256
) (
   input  logic     clock,
   input  logic     reset,
   input  csr_type  csr,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   localparam int TW  = MAX_TABLE_LOG;
   localparam int SW  = MAX_TABLE_LOG + 1;
   localparam int WDW = MAX_TABLE_LOG + 2;
   localparam int AW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int TD  = 1 << MAX_TABLE_LOG;
   localparam logic [3:0] RESET_LOG =
      (int'(TABLE_LOG_RESET) > MAX_TABLE_LOG) ? 4'(MAX_TABLE_LOG) : TABLE_LOG_RESET;

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_REC_RD    = 14'b00000000000010,
      S_REC       = 14'b00000000000100,
      S_SPR_RD    = 14'b00000000001000,
      S_SPR_LEN   = 14'b00000000010000,
      S_SPR_WR    = 14'b00000000100000,
      S_FIL_RD    = 14'b00000001000000,
      S_FIL_SYM   = 14'b00000010000000,
      S_FIL_WR    = 14'b00000100000000,
      S_BDONE     = 14'b00001000000000,
      S_ENC_REC   = 14'b00010000000000,
      S_ENC_SHIFT = 14'b00100000000000,
      S_ENC_NEXT  = 14'b01000000000000,
      S_FIN       = 14'b10000000000000
   } state_type;

   // tables
   logic [12:0]    freq_mem     [ALPHABET];
   logic [3:0]     bits_mem     [ALPHABET];
   logic [WDW-1:0] thr_mem      [ALPHABET];
   logic [WDW-1:0] off_mem      [ALPHABET];
   logic [SW-1:0]  ivl_mem      [ALPHABET];
   logic [7:0]     spread_mem   [TD];
   logic [SW-1:0]  next_mem     [TD];

   logic [12:0]    freq_rd;
   logic [3:0]     bits_rd;
   logic [WDW-1:0] thr_rd, off_rd;
   logic [SW-1:0]  ivl_rd, next_rd;
   logic [7:0]     spread_rd;

   state_type      state_ff, state_in;
   logic [AW:0]    s_ff, s_in;
   logic [SW-1:0]  pos_ff, pos_in;
   logic [TW-1:0]  p_ff, p_in;
   logic [12:0]    remain_ff, remain_in;
   logic [SW-1:0]  coder_ff, coder_in;
   logic [7:0]     acc_ff, acc_in;
   logic [3:0]     free_ff, free_in;
   logic [3:0]     nb_ff, nb_in;
   logic [SW-1:0]  st_ff, st_in;
   logic [WDW-1:0] eoff_ff, eoff_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic [3:0]     tl;
   logic [SW-1:0]  size;
   logic [TW-1:0]  tmask, step;
   logic [AW:0]    n;
   logic [8:0]     n_wide;
   logic           out_free;
   logic           emit;
   rsp_type        emit_word;

   // record computation
   logic [3:0]     h;
   logic [3:0]     bo;
   logic [WDW-1:0] th;

   // encode chunk
   logic [3:0]     k;
   logic [7:0]     chunk, kmask, acc_new;
   logic [3:0]     free_new;

   // memory write controls
   logic           freq_we, rec_we, ivl_we, spread_we, next_we;
   logic [AW-1:0]  freq_wa, ivl_wa, rec_ra, ivl_ra;
   logic [SW-1:0]  ivl_wd;
   logic [TW-1:0]  next_wa, next_ra;

   assign tl = (csr.table_log < MIN_TABLE_LOG) ? MIN_TABLE_LOG :
               ((int'(csr.table_log) > MAX_TABLE_LOG) ? 4'(MAX_TABLE_LOG) : csr.table_log);
   assign size   = SW'(1) << tl;
   assign tmask  = TW'(size - SW'(1));
   assign step   = TW'(csr.spread_step) & tmask;
   assign n_wide = (csr.alphabet_size > 9'(ALPHABET)) ? 9'(ALPHABET) : csr.alphabet_size;
   assign n      = (AW + 1)'(n_wide);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      h = 4'd0;
      for (int i = 1; i < 13; i++) begin
         if (freq_rd[i]) h = 4'(i);
      end
   end
   assign bo = (freq_rd == 13'd0) ? 4'd0 : ((h <= tl) ? (tl - h) : 4'd0);
   assign th = (freq_rd == 13'd0) ? '0 : (WDW'(freq_rd) << bo);

   assign k        = (nb_ff < free_ff) ? nb_ff : free_ff;
   assign kmask    = 8'((9'd1 << k) - 9'd1);
   assign chunk    = 8'(st_ff) & kmask;
   assign acc_new  = 8'((16'(acc_ff) << k) | 16'(chunk));
   assign free_new = free_ff - k;

   assign rec_ra  = AW'(q_item.symbol);
   assign ivl_ra  = AW'(spread_rd);
   assign next_ra = TW'(st_ff) + TW'(eoff_ff);

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      pos_in       = pos_ff;
      p_in         = p_ff;
      remain_in    = remain_ff;
      coder_in     = coder_ff;
      acc_in       = acc_ff;
      free_in      = free_ff;
      nb_in        = nb_ff;
      st_in        = st_ff;
      eoff_in      = eoff_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      emit_word    = '0;
      freq_we      = 1'b0;
      freq_wa      = AW'(q_item.symbol);
      rec_we       = 1'b0;
      ivl_we       = 1'b0;
      ivl_wa       = AW'(s_ff);
      ivl_wd       = pos_ff;
      spread_we    = 1'b0;
      next_we      = 1'b0;
      next_wa      = TW'(ivl_rd);

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.cmd)
                  CMD_LOAD: begin
                     freq_we = 1'b1;
                  end
                  CMD_BUILD: begin
                     s_in     = '0;
                     pos_in   = '0;
                     state_in = (n == '0) ? S_SPR_RD : S_REC_RD;
                  end
                  CMD_ENCODE: begin
                     state_in = S_ENC_REC;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_REC_RD: begin
            state_in = S_REC;
         end
         S_REC: begin
            rec_we = 1'b1;
            ivl_we = 1'b1;
            pos_in = pos_ff + SW'(freq_rd);
            if (s_ff + 1'b1 == n) begin
               s_in     = '0;
               p_in     = '0;
               state_in = S_SPR_RD;
            end else begin
               s_in     = s_ff + 1'b1;
               state_in = S_REC_RD;
            end
         end
         S_SPR_RD: begin
            if (s_ff == n) begin
               p_in     = '0;
               state_in = S_FIL_RD;
            end else begin
               state_in = S_SPR_LEN;
            end
         end
         S_SPR_LEN: begin
            remain_in = freq_rd;
            if (freq_rd == 13'd0) begin
               s_in     = s_ff + 1'b1;
               state_in = S_SPR_RD;
            end else begin
               state_in = S_SPR_WR;
            end
         end
         S_SPR_WR: begin
            spread_we = 1'b1;
            p_in      = (p_ff + step) & tmask;
            remain_in = remain_ff - 13'd1;
            if (remain_ff == 13'd1) begin
               s_in     = s_ff + 1'b1;
               state_in = S_SPR_RD;
            end
         end
         S_FIL_RD: begin
            state_in = S_FIL_SYM;
         end
         S_FIL_SYM: begin
            if (9'(spread_rd) >= 9'(ALPHABET)) begin
               p_in     = p_ff + 1'b1;
               state_in = (p_ff == tmask) ? S_BDONE : S_FIL_RD;
            end else begin
               state_in = S_FIL_WR;
            end
         end
         S_FIL_WR: begin
            next_we  = 1'b1;
            ivl_we   = 1'b1;
            ivl_wa   = AW'(spread_rd);
            ivl_wd   = ivl_rd + SW'(1);
            p_in     = p_ff + 1'b1;
            state_in = (p_ff == tmask) ? S_BDONE : S_FIL_RD;
         end
         S_BDONE: begin
            if (out_free) begin
               emit            = 1'b1;
               emit_word.kind  = KIND_BUILD;
               emit_word.last  = 1'b1;
               coder_in        = size;
               acc_in          = 8'd0;
               free_in         = BYTE_BITS;
               state_in        = S_IDLE;
            end
         end
         S_ENC_REC: begin
            nb_in   = ((WDW'(coder_ff) < thr_rd) && (bits_rd != 4'd0)) ?
                      bits_rd - 4'd1 : bits_rd;
            st_in   = coder_ff;
            eoff_in = off_rd;
            state_in = S_ENC_SHIFT;
         end
         S_ENC_SHIFT: begin
            if (nb_ff == 4'd0) begin
               state_in = S_ENC_NEXT;
            end else if (free_new != 4'd0) begin
               acc_in  = acc_new;
               free_in = free_new;
               nb_in   = nb_ff - k;
               st_in   = st_ff >> k;
            end else if (out_free) begin
               // byte full: hand it out and start a fresh one
               emit                   = 1'b1;
               emit_word.kind         = KIND_BYTE;
               emit_word.byte_value   = acc_new;
               emit_word.bits_in_byte = BYTE_BITS;
               emit_word.last         = ((nb_ff - k) < BYTE_BITS);
               acc_in  = 8'd0;
               free_in = BYTE_BITS;
               nb_in   = nb_ff - k;
               st_in   = st_ff >> k;
            end
         end
         S_ENC_NEXT: begin
            coder_in = next_rd;
            state_in = S_IDLE;
         end
         S_FIN: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_word.kind         = KIND_FINAL;
               emit_word.byte_value   = acc_ff;
               emit_word.bits_in_byte = BYTE_BITS - free_ff;
               emit_word.final_state  = 12'(TW'(coder_ff - size));
               emit_word.last         = 1'b1;
               coder_in = size;
               acc_in   = 8'd0;
               free_in  = BYTE_BITS;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         coder_ff     <= SW'(1) << RESET_LOG;
         acc_ff       <= 8'd0;
         free_ff      <= BYTE_BITS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coder_ff     <= coder_in;
         acc_ff       <= acc_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      pos_ff    <= pos_in;
      p_ff      <= p_in;
      remain_ff <= remain_in;
      nb_ff     <= nb_in;
      st_ff     <= st_in;
      eoff_ff   <= eoff_in;
      rsp_ff    <= rsp_in;
   end

   // symbol tables
   always_ff @(posedge clock) begin
      if (freq_we) freq_mem[freq_wa] <= q_item.frequency;
      freq_rd <= freq_mem[AW'(s_ff)];
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         bits_mem[AW'(s_ff)] <= bo;
         thr_mem[AW'(s_ff)]  <= th;
         off_mem[AW'(s_ff)]  <= WDW'(pos_ff) - WDW'(freq_rd);
      end
      bits_rd <= bits_mem[rec_ra];
      thr_rd  <= thr_mem[rec_ra];
      off_rd  <= off_mem[rec_ra];
   end

   always_ff @(posedge clock) begin
      if (ivl_we) ivl_mem[ivl_wa] <= ivl_wd;
      ivl_rd <= ivl_mem[ivl_ra];
   end

   always_ff @(posedge clock) begin
      if (spread_we) spread_mem[p_ff] <= 8'(s_ff);
      spread_rd <= spread_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= SW'(p_ff) + size;
      next_rd <= next_mem[next_ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/tans_table_build_and_encode_top.sv =====
// Top level of the tANS table build and encode block.
// Items are taken into a two-word queue and carried out one at a time by a
// sequencer over its tables. An encode reads the symbol's record, moves the
// state bits into the byte in chunks (none to three chunks), then reads the
// next state. A build walks the tables serially: it reads and writes each
// symbol's record, spreads each symbol over one table entry per unit of its
// frequency, then fills the next-state table entry by entry. A result
// waiting in the output register stalls the sequencer only when another
// result is due.
module tans_table_build_and_encode_top import tans_pkg::*; #(
   parameter int MAX_TABLE_LOG = 12,
   parameter int ALPHABET      = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [12:0] req_frequency,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [3:0]  rsp_bits_in_byte,
   output logic [11:0] rsp_final_state,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   csr_type  csr_ff;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;
   rsp_type  rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.table_log     <= TABLE_LOG_RESET;
         csr_ff.spread_step   <= SPREAD_STEP_RESET;
         csr_ff.alphabet_size <= ALPHABET_SIZE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TABLE_LOG:     csr_ff.table_log     <= csr_data[3:0];
            CSR_SPREAD_STEP:   csr_ff.spread_step   <= csr_data;
            CSR_ALPHABET_SIZE: csr_ff.alphabet_size <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   tans_front #(.ALPHABET(ALPHABET)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_symbol    (req_symbol),
      .req_frequency (req_frequency),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   tans_back #(.MAX_TABLE_LOG(MAX_TABLE_LOG), .ALPHABET(ALPHABET)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_byte_value   = rsp.byte_value;
   assign rsp_bits_in_byte = rsp.bits_in_byte;
   assign rsp_final_state  = rsp.final_state;
   assign rsp_last         = rsp.last;

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_FINAL) |-> rsp_last)
      else $error("final result not marked last");

   a_build_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BUILD) |->
         rsp_last && (rsp_bits_in_byte == 4'd0) && (rsp_byte_value == 8'd0))
      else $error("build done word carries data");

   a_byte_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BYTE) |->
         (rsp_bits_in_byte == BYTE_BITS) && (rsp_final_state == 12'd0))
      else $error("stream byte not full");

endmodule
